@@ rtl/llac_pkg.sv @@
// Shared types, codes and a helper function for the link-local address claimer.
package llac_pkg;

   typedef enum logic [2:0] {
      PH_DISABLED = 3'd0,
      PH_INIT     = 3'd1,
      PH_WAIT     = 3'd2,
      PH_PROBE    = 3'd3,
      PH_ANNOUNCE = 3'd4,
      PH_BOUND    = 3'd5,
      PH_DEFEND   = 3'd6
   } phase_type;

   localparam logic [1:0] OP_POLL    = 2'd0;
   localparam logic [1:0] OP_START   = 2'd1;
   localparam logic [1:0] OP_RELEASE = 2'd2;

   localparam logic [1:0] IF_NONE  = 2'd0;
   localparam logic [1:0] IF_CLEAR = 2'd1;
   localparam logic [1:0] IF_APPLY = 2'd2;

   localparam logic REG_PROPOSED = 1'b0;
   localparam logic REG_DEFEND   = 1'b1;

   localparam logic [15:0] LL_NET_HI       = 16'hA9FE;
   localparam logic [15:0] BACKOFF_MS      = 16'd60000;
   localparam logic [15:0] PROBE_BASE_MS   = 16'd1000;
   localparam logic [31:0] ANNOUNCE_GAP_MS = 32'd2000;
   localparam logic [31:0] DEFEND_GAP_MS   = 32'd10000;
   localparam logic [3:0]  MAX_CONFLICTS   = 4'd10;
   localparam logic [3:0]  COLL_MAX        = 4'd15;
   localparam logic [1:0]  PROBES_NEEDED   = 2'd3;
   localparam logic [1:0]  ANNOUNCE_NUM    = 2'd2;
   localparam logic [1:0]  COUNT_MAX       = 2'd3;

   typedef struct packed {
      logic [31:0] proposed_address;
      logic        defend_enable;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  operation;
      logic [31:0] now_ms;
      logic [15:0] random_addr;
      logic [31:0] random_wait;
      logic        arp_hit;
      logic        addr_conflict;
      logic        addr_is_auto;
   } item_type;

   typedef struct packed {
      logic [2:0]  fsm_state;
      logic [31:0] claim_addr;
      logic        send_arp;
      logic        is_probe;
      logic [1:0]  interface_action;
      logic        clear_conflict;
      logic        enabled;
      logic        rejected;
   } result_type;

   // Remainder by 1000, folding bytes with their weights modulo 1000.
   function automatic logic [9:0] mod1000(input logic [31:0] v);
      logic [17:0] s1;
      logic [12:0] s2;
      logic [10:0] s3;
      logic [10:0] r;
      s1 = 18'(v[7:0]) + (18'(v[15:8]) << 8) + 18'(v[23:16]) * 18'd536
         + 18'(v[31:24]) * 18'd216;
      s2 = 13'(s1[9:0]) + 13'(s1[17:10]) * 13'd24;
      s3 = 11'(s2[9:0]) + 11'(s2[12:10]) * 11'd24;
      r = (s3 >= 11'd1000) ? (s3 - 11'd1000) : s3;
      return r[9:0];
   endfunction

endpackage

@@ rtl/llac_csr.sv @@
// Configuration register file with APB-style access.
module llac_csr (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [2:0]           csr_paddr,
   input  logic [31:0]          csr_pwdata,
   output logic [31:0]          csr_prdata,
   output logic                 csr_pready,
   output llac_pkg::cfg_type    cfg
);
   import llac_pkg::*;

   logic [31:0] proposed_ff;
   logic [31:0] proposed_in;
   logic        defend_ff;
   logic        defend_in;
   logic        wr_en;

   assign csr_pready = 1'b1;
   assign wr_en = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      proposed_in = proposed_ff;
      defend_in = defend_ff;
      if (wr_en) begin
         case (csr_paddr[2])
            REG_PROPOSED: proposed_in = csr_pwdata;
            REG_DEFEND:   defend_in = csr_pwdata[0];
            default:      ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         proposed_ff <= '0;
         defend_ff <= 1'b1;
      end else begin
         proposed_ff <= proposed_in;
         defend_ff <= defend_in;
      end
   end

   always_comb begin
      case (csr_paddr[2])
         REG_PROPOSED: csr_prdata = proposed_ff;
         REG_DEFEND:   csr_prdata = {31'd0, defend_ff};
         default:      csr_prdata = '0;
      endcase
   end

   assign cfg.proposed_address = proposed_ff;
   assign cfg.defend_enable = defend_ff;

endmodule

@@ rtl/llac_core.sv @@
// Claim sequence state and the single-pass next-state and result logic.
module llac_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  llac_pkg::item_type    item,
   input  llac_pkg::cfg_type     cfg,
   output llac_pkg::result_type  result
);
   import llac_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [31:0] cand_ff, cand_in;
   logic        reuse_ff, reuse_in;
   logic [31:0] init_stamp_ff, init_stamp_in;
   logic [31:0] probe_stamp_ff, probe_stamp_in;
   logic [31:0] ann_stamp_ff, ann_stamp_in;
   logic [31:0] def_stamp_ff, def_stamp_in;
   logic [15:0] span_ff, span_in;
   logic [1:0]  pcount_ff, pcount_in;
   logic [1:0]  acount_ff, acount_in;
   logic [3:0]  coll_ff, coll_in;

   logic [9:0]  rand_ms;
   logic [31:0] new_cand;
   logic        running;
   logic        go_init, go_probe, go_ann, go_defend;
   logic        do_probe, do_announce;
   logic [1:0]  pcount_base, acount_base;
   logic        act_arp, act_probe, act_clear, rej;
   logic [1:0]  act_if;

   assign rand_ms = mod1000(item.random_wait);
   assign new_cand = {LL_NET_HI, item.random_addr[15:9], 1'b1, item.random_addr[7:0]};
   assign running = (phase_ff != PH_DISABLED);

   always_comb begin
      phase_in = phase_ff;
      cand_in = cand_ff;
      reuse_in = reuse_ff;
      init_stamp_in = init_stamp_ff;
      probe_stamp_in = probe_stamp_ff;
      ann_stamp_in = ann_stamp_ff;
      def_stamp_in = def_stamp_ff;
      span_in = span_ff;
      pcount_in = pcount_ff;
      acount_in = acount_ff;
      coll_in = coll_ff;
      go_init = 1'b0;
      go_probe = 1'b0;
      go_ann = 1'b0;
      go_defend = 1'b0;
      do_probe = 1'b0;
      do_announce = 1'b0;
      act_arp = 1'b0;
      act_probe = 1'b0;
      act_if = IF_NONE;
      act_clear = 1'b0;
      rej = 1'b0;

      case (item.operation)
         OP_POLL: begin
            case (phase_ff)
               PH_INIT: begin
                  if (!reuse_ff) begin
                     cand_in = new_cand;
                  end
                  reuse_in = 1'b0;
                  phase_in = PH_WAIT;
                  span_in = 16'(rand_ms)
                          + ((coll_ff >= MAX_CONFLICTS) ? BACKOFF_MS : 16'd0);
               end
               PH_WAIT: begin
                  if ((item.now_ms - init_stamp_ff) > 32'(span_ff)) begin
                     go_probe = 1'b1;
                  end
               end
               PH_PROBE: begin
                  if (item.arp_hit || item.addr_conflict) begin
                     if (coll_ff < COLL_MAX) begin
                        coll_in = coll_ff + 4'd1;
                     end
                     go_init = 1'b1;
                  end else if (pcount_ff >= PROBES_NEEDED) begin
                     go_ann = 1'b1;
                  end else if ((item.now_ms - probe_stamp_ff) > 32'(span_ff)) begin
                     do_probe = 1'b1;
                  end
               end
               PH_ANNOUNCE: begin
                  if (acount_ff >= ANNOUNCE_NUM) begin
                     phase_in = PH_BOUND;
                  end else if (item.addr_conflict) begin
                     go_init = 1'b1;
                  end else if ((item.now_ms - ann_stamp_ff) > ANNOUNCE_GAP_MS) begin
                     do_announce = 1'b1;
                  end
               end
               PH_BOUND: begin
                  if (!item.addr_is_auto) begin
                     phase_in = PH_DISABLED;
                  end else if (item.addr_conflict) begin
                     if (cfg.defend_enable) begin
                        go_defend = 1'b1;
                     end else begin
                        go_init = 1'b1;
                     end
                  end
               end
               PH_DEFEND: begin
                  if (!item.addr_is_auto) begin
                     phase_in = PH_DISABLED;
                  end else if (item.addr_conflict) begin
                     go_init = 1'b1;
                  end else if ((item.now_ms - def_stamp_ff) > DEFEND_GAP_MS) begin
                     phase_in = PH_BOUND;
                  end
               end
               default: ;
            endcase
         end
         OP_START: begin
            if (running) begin
               rej = 1'b1;
            end else begin
               if (cfg.proposed_address[31:16] == LL_NET_HI) begin
                  cand_in = cfg.proposed_address;
                  reuse_in = 1'b1;
               end else begin
                  cand_in = '0;
                  reuse_in = 1'b0;
               end
               probe_stamp_in = '0;
               ann_stamp_in = '0;
               def_stamp_in = '0;
               span_in = '0;
               pcount_in = '0;
               acount_in = '0;
               coll_in = '0;
               go_init = 1'b1;
            end
         end
         OP_RELEASE: begin
            if (running) begin
               phase_in = PH_DISABLED;
            end
         end
         default: ;
      endcase

      if (go_init) begin
         phase_in = PH_INIT;
         init_stamp_in = item.now_ms;
         act_if = IF_CLEAR;
      end
      if (go_probe) begin
         phase_in = PH_PROBE;
         do_probe = 1'b1;
      end
      if (go_ann) begin
         phase_in = PH_ANNOUNCE;
         coll_in = '0;
         act_if = IF_APPLY;
         do_announce = 1'b1;
      end
      if (go_defend) begin
         phase_in = PH_DEFEND;
         def_stamp_in = item.now_ms;
         act_clear = 1'b1;
         do_announce = 1'b1;
      end

      pcount_base = go_probe ? 2'd0 : pcount_ff;
      acount_base = go_ann ? 2'd0 : acount_ff;
      if (go_ann) begin
         acount_in = 2'd0;
      end
      if (do_probe) begin
         probe_stamp_in = item.now_ms;
         span_in = 16'(rand_ms) + PROBE_BASE_MS;
         act_arp = 1'b1;
         act_probe = 1'b1;
         pcount_in = (pcount_base < COUNT_MAX) ? (pcount_base + 2'd1) : pcount_base;
      end
      if (do_announce) begin
         ann_stamp_in = item.now_ms;
         act_arp = 1'b1;
         acount_in = (acount_base < COUNT_MAX) ? (acount_base + 2'd1) : acount_base;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_DISABLED;
         cand_ff <= '0;
         reuse_ff <= 1'b0;
         init_stamp_ff <= '0;
         probe_stamp_ff <= '0;
         ann_stamp_ff <= '0;
         def_stamp_ff <= '0;
         span_ff <= '0;
         pcount_ff <= '0;
         acount_ff <= '0;
         coll_ff <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         cand_ff <= cand_in;
         reuse_ff <= reuse_in;
         init_stamp_ff <= init_stamp_in;
         probe_stamp_ff <= probe_stamp_in;
         ann_stamp_ff <= ann_stamp_in;
         def_stamp_ff <= def_stamp_in;
         span_ff <= span_in;
         pcount_ff <= pcount_in;
         acount_ff <= acount_in;
         coll_ff <= coll_in;
      end
   end

   assign result.fsm_state = phase_in;
   assign result.claim_addr = cand_in;
   assign result.send_arp = act_arp;
   assign result.is_probe = act_probe;
   assign result.interface_action = act_if;
   assign result.clear_conflict = act_clear;
   assign result.enabled = (phase_in != PH_DISABLED);
   assign result.rejected = rej;

endmodule

@@ rtl/link_local_address_claimer.sv @@
// Top level of the link-local address claimer: channel registers around the claim logic.
// Each request transfer carries one start, poll or release event and yields exactly one
// response transfer. A request is captured in an input register, evaluated against the
// claim state in a single combinational pass, and its response lands in an output
// register; one request is taken every cycle while the response side keeps up.
// The two registers of the configuration port must be written only while no event is in
// flight; the block itself does not enforce this.
module link_local_address_claimer (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [87:0]  req_tdata,   // now_ms, random_addr, random_wait, arp_hit,
                                     // addr_conflict, addr_is_auto, zero fill
   input  logic [1:0]   req_tuser,   // operation
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [47:0]  rsp_tdata,   // fsm_state, claim_addr, send_arp, is_probe,
                                     // interface_action, clear_conflict, enabled,
                                     // rejected, zero fill
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);
   import llac_pkg::*;

   cfg_type    cfg;
   item_type   in_item_ff, in_item_in;
   logic       in_valid_ff, in_valid_in;
   result_type out_res_ff, out_res_in;
   logic       out_valid_ff, out_valid_in;
   result_type core_res;
   logic       advance;
   logic       req_fire;

   llac_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   llac_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (in_item_ff),
      .cfg    (cfg),
      .result (core_res)
   );

   assign advance = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || !out_valid_ff || rsp_tready;
   assign req_fire = req_tvalid && req_tready;

   always_comb begin
      in_item_in = in_item_ff;
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_item_in.operation = req_tuser;
         in_item_in.now_ms = req_tdata[31:0];
         in_item_in.random_addr = req_tdata[47:32];
         in_item_in.random_wait = req_tdata[79:48];
         in_item_in.arp_hit = req_tdata[80];
         in_item_in.addr_conflict = req_tdata[81];
         in_item_in.addr_is_auto = req_tdata[82];
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      out_res_in = out_res_ff;
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_res_in = core_res;
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      in_item_ff <= in_item_in;
      out_res_ff <= out_res_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata = {6'd0, out_res_ff.rejected, out_res_ff.enabled,
                       out_res_ff.clear_conflict, out_res_ff.interface_action,
                       out_res_ff.is_probe, out_res_ff.send_arp,
                       out_res_ff.claim_addr, out_res_ff.fsm_state};

   a_stalled_item_kept: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff)
      else $error("Waiting request was dropped.");

   a_disabled_state: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_res_ff.enabled |-> out_res_ff.fsm_state == PH_DISABLED)
      else $error("Stopped service reports an active state.");

   a_probe_arp: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_res_ff.is_probe |->
         out_res_ff.send_arp && out_res_ff.fsm_state == PH_PROBE)
      else $error("Probe reported outside the probe state.");

   a_apply_announce: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_res_ff.interface_action == IF_APPLY |->
         out_res_ff.fsm_state == PH_ANNOUNCE && out_res_ff.send_arp)
      else $error("Address applied without an announcement.");

   a_reject_running: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_res_ff.rejected |-> out_res_ff.enabled)
      else $error("Start rejected while the service was stopped.");

endmodule
